[design/u8d_pkg.sv]
// shared types, constants and byte classification for the utf-8 decoder
// no dependencies
`default_nettype none

package u8d_pkg;

   localparam int CP_W       = 21;
   localparam int BYTE_W     = 8;
   localparam int HOLD_DEPTH = 4;
   localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
   localparam int IDX_W      = $clog2(HOLD_DEPTH);
   localparam int EXTRA_W    = 2;
   localparam int CONT_BITS  = 6;

   localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;

   // byte class: plain ascii, lead of a 2/3/4 byte sequence, or stray
   typedef enum logic [2:0] {
      CLS_SINGLE = 3'd0,
      CLS_LEAD2  = 3'd1,
      CLS_LEAD3  = 3'd2,
      CLS_LEAD4  = 3'd3,
      CLS_STRAY  = 3'd4
   } cls_type;

   typedef struct packed {
      logic start;
      logic step;
   } asm_ctrl_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             last;
      logic             bad;
   } asm_status_type;

   function automatic cls_type classify(input logic [BYTE_W-1:0] b);
      cls_type c;
      if (!b[7]) begin
         c = CLS_SINGLE;
      end else if (b[7:5] == 3'b110) begin
         c = CLS_LEAD2;
      end else if (b[7:4] == 4'b1110) begin
         c = CLS_LEAD3;
      end else if (b[7:3] == 5'b11110) begin
         c = CLS_LEAD4;
      end else begin
         c = CLS_STRAY;
      end
      return c;
   endfunction

   // continuation bytes a lead class asks for
   function automatic logic [EXTRA_W-1:0] extra_of(input cls_type c);
      logic [2:0] v;
      v = c;
      return v[EXTRA_W-1:0];
   endfunction

   // payload bits carried by a lead byte
   function automatic logic [CP_W-1:0] lead_payload(input logic [BYTE_W-1:0] b);
      logic [CP_W-1:0] p;
      case (classify(b))
         CLS_LEAD2: p = CP_W'(b[4:0]);
         CLS_LEAD3: p = CP_W'(b[3:0]);
         CLS_LEAD4: p = CP_W'(b[2:0]);
         default:   p = '0;
      endcase
      return p;
   endfunction

   function automatic logic is_cont(input logic [BYTE_W-1:0] b);
      return b[7:6] == 2'b10;
   endfunction

endpackage

`default_nettype wire

[design/utf8_codepoint_decoder.sv]
// streaming utf-8 decoder top level: hold buffer, sequencer, result staging
// depends on u8d_pkg and u8d_assembler
`default_nettype none

// utf8_codepoint_decoder takes one text byte per req beat (req_text_end marks
// the final byte of a text) and gives zero to four code points per byte on the
// rsp channel, with rsp_run_last set on the last result a byte causes. ascii
// passes through; 2, 3 and 4 byte sequences are held until complete and then
// checked and merged one continuation byte per cycle by a shared shift-merge
// unit. stray bytes, bad continuations and sequences cut off by the end of the
// text give the value of the replacement register (csr beat, reset 0xFFFD)
// with rsp_replaced set. a bad continuation consumes only the lead byte and
// the held bytes behind it are scanned again. one byte is worked at a time and
// req_stall is high meanwhile: the sequencer scans the held buffer, then the
// single shift-merge unit checks and merges each continuation byte in turn, and
// a bad continuation forces a rescan; a stalled rsp side holds the work longer.
// the replacement register should be written only while the block is idle.
module utf8_codepoint_decoder (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // byte input
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [u8d_pkg::BYTE_W-1:0]    req_text_byte,
   input  wire logic                          req_text_end,
   // code point output
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [u8d_pkg::CP_W-1:0]           rsp_code_point,
   output logic                               rsp_replaced,
   output logic                               rsp_run_last,
   // replacement register write
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [u8d_pkg::CP_W-1:0]      csr_replacement_code
);
   import u8d_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ASSEMBLE
   } state_type;

   state_type           state_ff, state_in;
   logic [BYTE_W-1:0]   held_ff [HOLD_DEPTH];
   logic [BYTE_W-1:0]   held_in [HOLD_DEPTH];
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                end_ff, end_in;
   logic [CP_W-1:0]     repl_ff, repl_in;

   // one result held back until we know whether it is the byte's last
   logic                pend_valid_ff, pend_valid_in;
   logic [CP_W-1:0]     pend_cp_ff, pend_cp_in;
   logic                pend_rep_ff, pend_rep_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CP_W-1:0]     rsp_cp_ff, rsp_cp_in;
   logic                rsp_rep_ff, rsp_rep_in;
   logic                rsp_last_ff, rsp_last_in;

   // shared shift-merge unit
   asm_ctrl_type        asm_ctrl;
   asm_status_type      asm_status;
   logic [CP_W-1:0]     asm_cp;
   logic [BYTE_W-1:0]   cont_byte;

   // head of the hold buffer
   logic [BYTE_W-1:0]   head;
   cls_type             head_cls;
   logic [CNT_W-1:0]    seq_len;

   assign head      = held_ff[0];
   assign head_cls  = classify(head);
   assign seq_len   = CNT_W'(extra_of(head_cls)) + CNT_W'(1);
   assign cont_byte = held_ff[asm_status.idx];

   u8d_assembler u_assembler (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (asm_ctrl),
      .lead_byte  (head),
      .cont_byte  (cont_byte),
      .status     (asm_status),
      .code_point (asm_cp)
   );

   assign req_stall      = (state_ff != ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_point = rsp_cp_ff;
   assign rsp_replaced   = rsp_rep_ff;
   assign rsp_run_last   = rsp_last_ff;

   always_comb begin
      logic             slot_free;
      logic             can_emit;
      logic             want_emit;
      logic [CP_W-1:0]  emit_cp;
      logic             emit_rep;
      logic [CNT_W-1:0] drop;
      logic             clear;
      logic             finish;
      logic [CNT_W-1:0] src;

      state_in      = state_ff;
      held_in       = held_ff;
      count_in      = count_ff;
      end_in        = end_ff;
      repl_in       = csr_valid ? csr_replacement_code : repl_ff;
      pend_valid_in = pend_valid_ff;
      pend_cp_in    = pend_cp_ff;
      pend_rep_in   = pend_rep_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_cp_in     = rsp_cp_ff;
      rsp_rep_in    = rsp_rep_ff;
      rsp_last_in   = rsp_last_ff;
      asm_ctrl      = '0;

      want_emit = 1'b0;
      emit_cp   = repl_ff;
      emit_rep  = 1'b1;
      drop      = '0;
      clear     = 1'b0;
      finish    = 1'b0;
      src       = '0;

      // output beat taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      slot_free = !rsp_valid_ff || !rsp_stall;
      can_emit  = !pend_valid_ff || slot_free;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               held_in[count_ff[IDX_W-1:0]] = req_text_byte;
               count_in = count_ff + CNT_W'(1);
               end_in   = req_text_end;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (count_ff == '0) begin
               finish = 1'b1;
            end else begin
               case (head_cls)
                  CLS_SINGLE: begin
                     want_emit = 1'b1;
                     emit_cp   = CP_W'(head);
                     emit_rep  = 1'b0;
                     drop      = CNT_W'(1);
                  end
                  CLS_STRAY: begin
                     want_emit = 1'b1;
                     drop      = CNT_W'(1);
                  end
                  default: begin
                     if (count_ff < seq_len) begin
                        // sequence incomplete: wait, or give it up at end of text
                        if (end_ff) begin
                           want_emit = 1'b1;
                           clear     = 1'b1;
                        end else begin
                           finish = 1'b1;
                        end
                     end else begin
                        asm_ctrl.start = 1'b1;
                        state_in       = ST_ASSEMBLE;
                     end
                  end
               endcase
            end
         end
         ST_ASSEMBLE: begin
            if (asm_status.bad) begin
               // bad continuation: drop only the lead and rescan the rest
               want_emit = 1'b1;
               drop      = CNT_W'(1);
            end else if (asm_status.last) begin
               want_emit = 1'b1;
               emit_cp   = asm_cp;
               emit_rep  = 1'b0;
               drop      = seq_len;
            end else begin
               asm_ctrl.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // new result: the held-back one goes out as not last
      if (want_emit && can_emit) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_cp_in    = pend_cp_ff;
            rsp_rep_in   = pend_rep_ff;
            rsp_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_cp_in    = emit_cp;
         pend_rep_in   = emit_rep;
         state_in      = ST_SCAN;
         if (clear) begin
            count_in = '0;
         end else begin
            count_in = count_ff - drop;
            for (int i = 0; i < HOLD_DEPTH; i++) begin
               src = CNT_W'(i) + drop;
               if (src < CNT_W'(HOLD_DEPTH)) begin
                  held_in[i] = held_ff[src[IDX_W-1:0]];
               end
            end
         end
      end

      // byte done: the held-back result is its last
      if (finish) begin
         if (!pend_valid_ff) begin
            state_in = ST_IDLE;
         end else if (slot_free) begin
            rsp_valid_in  = 1'b1;
            rsp_cp_in     = pend_cp_ff;
            rsp_rep_in    = pend_rep_ff;
            rsp_last_in   = 1'b1;
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         end_ff        <= 1'b0;
         repl_ff       <= REPL_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         end_ff        <= end_in;
         repl_ff       <= repl_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      held_ff     <= held_in;
      pend_cp_ff  <= pend_cp_in;
      pend_rep_ff <= pend_rep_in;
      rsp_cp_ff   <= rsp_cp_in;
      rsp_rep_ff  <= rsp_rep_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef ASSERT_OFF
   // nothing may be left held back once the byte is finished
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held-back result left over in idle");

   // end of text leaves the hold buffer empty
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && end_ff) |-> (count_ff == '0))
      else $error("bytes still held after end of text");

   // there is always room for the next byte when idle
   a_idle_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (count_ff < CNT_W'(HOLD_DEPTH)))
      else $error("hold buffer full in idle");
`endif

endmodule

`default_nettype wire

[design/u8d_assembler.sv]
// shift-and-merge unit that builds a code point one continuation byte a cycle while stepped
// depends on u8d_pkg
`default_nettype none

module u8d_assembler (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire u8d_pkg::asm_ctrl_type         ctrl,
   input  wire logic [u8d_pkg::BYTE_W-1:0]    lead_byte,
   input  wire logic [u8d_pkg::BYTE_W-1:0]    cont_byte,
   output u8d_pkg::asm_status_type            status,
   output logic [u8d_pkg::CP_W-1:0]           code_point
);
   import u8d_pkg::*;

   logic [CP_W-1:0]    cp_ff,    cp_in;
   logic [IDX_W-1:0]   idx_ff,   idx_in;
   logic [EXTRA_W-1:0] extra_ff, extra_in;

   // value with the current continuation merged in
   assign code_point  = {cp_ff[CP_W-CONT_BITS-1:0], cont_byte[CONT_BITS-1:0]};
   assign status.idx  = idx_ff;
   assign status.last = (IDX_W'(extra_ff) == idx_ff);
   assign status.bad  = !is_cont(cont_byte);

   always_comb begin
      cp_in    = cp_ff;
      idx_in   = idx_ff;
      extra_in = extra_ff;
      if (ctrl.start) begin
         cp_in    = lead_payload(lead_byte);
         idx_in   = IDX_W'(1);
         extra_in = extra_of(classify(lead_byte));
      end else if (ctrl.step) begin
         cp_in  = code_point;
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= IDX_W'(1);
         extra_ff <= '0;
      end else begin
         idx_ff   <= idx_in;
         extra_ff <= extra_in;
      end
      cp_ff <= cp_in;
   end

endmodule

`default_nettype wire

[bench/u8d_codepoint_checker.sv]
// watches the byte, code point and replacement register channels of the utf-8 decoder,
// predicts the code points of every accepted byte and compares them beat by beat
// depends on u8d_pkg for widths and the byte class enum
`timescale 1ns / 1ps

module u8d_codepoint_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic [u8d_pkg::BYTE_W-1:0]    req_text_byte,
   input  wire logic                          req_text_end,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [u8d_pkg::CP_W-1:0]      rsp_code_point,
   input  wire logic                          rsp_replaced,
   input  wire logic                          rsp_run_last,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [u8d_pkg::CP_W-1:0]      csr_replacement_code,
   input  wire logic                          end_of_run,
   output int                                 check_failures,
   output int                                 cps_pending,
   output int                                 cps_checked,
   output int                                 cps_replaced
);

   import u8d_pkg::*;

   localparam logic [CP_W-1:0] REPL_AT_RESET = 21'h00FFFD;
   localparam int unsigned     HOLD_MAX      = 4;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            replaced;
      logic            run_last;
   } cp_result_type;

   cp_result_type   expected_cps[$];
   logic [7:0]      held_q[HOLD_MAX];
   int unsigned     held_n;
   logic [CP_W-1:0] repl_code;
   logic            leftovers_seen;

   function automatic cls_type byte_kind(input logic [7:0] b);
      if (b < 8'h80) return CLS_SINGLE;
      if ((b & 8'hE0) == 8'hC0) return CLS_LEAD2;
      if ((b & 8'hF0) == 8'hE0) return CLS_LEAD3;
      if ((b & 8'hF8) == 8'hF0) return CLS_LEAD4;
      return CLS_STRAY;
   endfunction

   function automatic cp_result_type cp_beat(input logic [CP_W-1:0] cp, input logic rep);
      cp_result_type r;
      r.code_point = cp;
      r.replaced   = rep;
      r.run_last   = 1'b0;
      return r;
   endfunction

   function automatic void drop_held(input int unsigned k);
      int unsigned i;
      if (k >= held_n) begin
         held_n = 0;
      end else begin
         for (i = 0; i + k < held_n; i++) held_q[i] = held_q[i + k];
         held_n -= k;
      end
   endfunction

   // works one accepted byte through the hold buffer, queues the code points it causes
   task automatic decode_byte(input logic [7:0] b, input logic text_last);
      cp_result_type   out_q[$];
      cls_type         kind;
      int unsigned     need;
      int unsigned     j;
      logic [CP_W-1:0] cp;
      logic            bad;
      if (held_n >= HOLD_MAX) held_n = 0;
      held_q[held_n] = b;
      held_n++;
      while (held_n > 0 && out_q.size() < HOLD_MAX) begin
         kind = byte_kind(held_q[0]);
         case (kind)
            CLS_LEAD2: begin
               need = 1;
               cp   = CP_W'(held_q[0][4:0]);
            end
            CLS_LEAD3: begin
               need = 2;
               cp   = CP_W'(held_q[0][3:0]);
            end
            CLS_LEAD4: begin
               need = 3;
               cp   = CP_W'(held_q[0][2:0]);
            end
            default: begin
               need = 0;
               cp   = CP_W'(held_q[0]);
            end
         endcase
         if (kind == CLS_SINGLE) begin
            out_q.push_back(cp_beat(cp, 1'b0));
            drop_held(1);
         end else if (kind == CLS_STRAY) begin
            out_q.push_back(cp_beat(repl_code, 1'b1));
            drop_held(1);
         end else if (held_n < need + 1) begin
            // incomplete: one replacement for the lot if the text ends here
            if (text_last) begin
               out_q.push_back(cp_beat(repl_code, 1'b1));
               held_n = 0;
            end
            break;
         end else begin
            bad = 1'b0;
            for (j = 1; j <= need; j++) begin
               if (held_q[j][7:6] != 2'b10) bad = 1'b1;
               cp = (cp << 6) | CP_W'(held_q[j][5:0]);
            end
            if (bad) begin
               // only the lead goes, the rest is scanned again
               out_q.push_back(cp_beat(repl_code, 1'b1));
               drop_held(1);
            end else begin
               out_q.push_back(cp_beat(cp, 1'b0));
               drop_held(need + 1);
            end
         end
      end
      if (text_last) held_n = 0;
      if (out_q.size() > 0) out_q[out_q.size() - 1].run_last = 1'b1;
      foreach (out_q[i]) expected_cps.push_back(out_q[i]);
   endtask

   always @(posedge clock) begin : watch
      cp_result_type got;
      cp_result_type want;
      if (reset) begin
         expected_cps.delete();
         held_n         = 0;
         repl_code      = REPL_AT_RESET;
         leftovers_seen = 1'b0;
      end else begin
         if (csr_valid && csr_ready) repl_code = csr_replacement_code;
         if (req_valid && !req_stall) decode_byte(req_text_byte, req_text_end);
         if (rsp_valid && !rsp_stall) begin
            got.code_point = rsp_code_point;
            got.replaced   = rsp_replaced;
            got.run_last   = rsp_run_last;
            if (expected_cps.size() == 0) begin
               $error("code point beat with nothing expected: code_point %h replaced %b",
                      got.code_point, got.replaced);
               check_failures++;
            end else begin
               want = expected_cps.pop_front();
               if (got.code_point != want.code_point) begin
                  $error("code_point mismatch: expected %h, actual %h",
                         want.code_point, got.code_point);
                  check_failures++;
               end
               if (got.replaced != want.replaced) begin
                  $error("replaced mismatch: expected %b, actual %b",
                         want.replaced, got.replaced);
                  check_failures++;
               end
               if (got.run_last != want.run_last) begin
                  $error("run_last mismatch: expected %b, actual %b",
                         want.run_last, got.run_last);
                  check_failures++;
               end
               cps_checked++;
               if (want.replaced) cps_replaced++;
            end
         end
         if (end_of_run && !leftovers_seen) begin
            leftovers_seen = 1'b1;
            if (expected_cps.size() != 0) begin
               $error("%0d expected code points never came out, oldest %h",
                      expected_cps.size(), expected_cps[0].code_point);
               check_failures += expected_cps.size();
            end
         end
      end
      cps_pending <= expected_cps.size();
   end

endmodule

[bench/tb_utf8_codepoint_decoder.sv]
// top of the utf-8 decoder bench: clock, reset, byte stimulus, rsp backpressure and verdict
// depends on u8d_pkg, utf8_codepoint_decoder and u8d_codepoint_checker
`timescale 1ns / 1ps

module tb_utf8_codepoint_decoder;

   import u8d_pkg::*;

   // far above the slowest legal run: ~230 bytes, each with its longest idle gap,
   // its longest busy time and four results each under the longest rsp stall
   localparam int CYCLE_LIMIT = 200000;
   // quiet cycles before a register write or the verdict, above the worst item latency
   localparam int SETTLE_CYCLES = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid     = 1'b0;
   logic              req_stall;
   logic [BYTE_W-1:0] req_text_byte = '0;
   logic              req_text_end  = 1'b0;

   logic              rsp_valid;
   logic              rsp_stall     = 1'b0;
   logic [CP_W-1:0]   rsp_code_point;
   logic              rsp_replaced;
   logic              rsp_run_last;

   logic              csr_valid     = 1'b0;
   logic              csr_ready;
   logic [CP_W-1:0]   csr_replacement_code = '0;

   logic              end_of_run    = 1'b0;
   int                check_failures;
   int                cps_pending;
   int                cps_checked;
   int                cps_replaced;

   int                bytes_sent;
   int                settings_used;
   int                req_quiet;
   int                cycles;

   always #5ns clock = ~clock;

   utf8_codepoint_decoder i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_text_byte        (req_text_byte),
      .req_text_end         (req_text_end),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_code_point       (rsp_code_point),
      .rsp_replaced         (rsp_replaced),
      .rsp_run_last         (rsp_run_last),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_replacement_code (csr_replacement_code)
   );

   u8d_codepoint_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_text_byte        (req_text_byte),
      .req_text_end         (req_text_end),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_code_point       (rsp_code_point),
      .rsp_replaced         (rsp_replaced),
      .rsp_run_last         (rsp_run_last),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_replacement_code (csr_replacement_code),
      .end_of_run           (end_of_run),
      .check_failures       (check_failures),
      .cps_pending          (cps_pending),
      .cps_checked          (cps_checked),
      .cps_replaced         (cps_replaced)
   );

   // one byte beat: optional idle gap, then hold the beat until it is taken.
   // valid is only lowered when a gap follows, so back-to-back beats keep it high
   task automatic push_byte(input logic [7:0] b, input logic text_last);
      int gap;
      if (req_quiet > 0) begin
         req_quiet--;
         gap = 0;
      end else if ($urandom_range(0, 15) == 0) begin
         // burst with no idling at all
         req_quiet = $urandom_range(8, 40);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 13);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      req_text_end  <= text_last;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // drain: no beat offered, every expected code point out, then a quiet stretch
   // so that a byte that produced nothing is also finished
   task automatic settle_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (cps_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_repl(input logic [CP_W-1:0] value);
      csr_valid            <= 1'b1;
      csr_replacement_code <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // one text of well-formed characters with random content, sometimes broken
   task automatic send_text(input int n_chars);
      logic [7:0]  bytes_q[$];
      logic [20:0] cp_bits;
      logic [7:0]  stray;
      int          len;
      int          k;
      int          pos;
      int          damage;
      for (k = 0; k < n_chars; k++) begin
         len     = $urandom_range(1, 4);
         cp_bits = CP_W'($urandom);
         case (len)
            1: bytes_q.push_back({1'b0, cp_bits[6:0]});
            2: begin
               bytes_q.push_back({3'b110, cp_bits[10:6]});
               bytes_q.push_back({2'b10, cp_bits[5:0]});
            end
            3: begin
               bytes_q.push_back({4'b1110, cp_bits[15:12]});
               bytes_q.push_back({2'b10, cp_bits[11:6]});
               bytes_q.push_back({2'b10, cp_bits[5:0]});
            end
            default: begin
               bytes_q.push_back({5'b11110, cp_bits[20:18]});
               bytes_q.push_back({2'b10, cp_bits[17:12]});
               bytes_q.push_back({2'b10, cp_bits[11:6]});
               bytes_q.push_back({2'b10, cp_bits[5:0]});
            end
         endcase
      end
      damage = $urandom_range(0, 9);
      pos    = $urandom_range(0, bytes_q.size() - 1);
      if (damage == 0) begin
         // any byte overwritten: bad continuation, stray or new lead
         bytes_q[pos] = 8'($urandom_range(0, 255));
      end else if (damage == 1 && bytes_q.size() > 1) begin
         // cut short, text likely ends inside a sequence
         void'(bytes_q.pop_back());
      end else if (damage == 2) begin
         stray = 8'($urandom_range(8'h80, 8'hBF));
         bytes_q.insert(pos, stray);
      end
      for (k = 0; k < bytes_q.size(); k++) push_byte(bytes_q[k], k == bytes_q.size() - 1);
   endtask

   // random texts mixed with raw noise bytes until the byte budget is used
   task automatic random_phase(input int budget);
      int stop_at;
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(0, 4) == 0) begin
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         end else begin
            send_text($urandom_range(1, 6));
         end
      end
      // close the last text so no partial sequence crosses into the next setting
      push_byte(8'($urandom_range(0, 127)), 1'b1);
   endtask

   // rsp side: a random stall before each result, with bursts of none
   initial begin : rsp_backpressure
      int hold;
      int quiet;
      quiet = 0;
      forever begin
         if (quiet > 0) begin
            quiet--;
            hold = 0;
         end else if ($urandom_range(0, 15) == 0) begin
            quiet = $urandom_range(8, 40);
            hold  = 0;
         end else begin
            hold = $urandom_range(0, 13);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // watchdog
   initial begin : watchdog
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      bytes_sent    = 0;
      settings_used = 1;
      req_quiet     = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, replacement at its reset value
      push_byte(8'h00, 1'b0);                   // lowest ascii
      push_byte(8'h7F, 1'b1);                   // highest ascii, end of text
      push_byte(8'hC2, 1'b0);                   // two byte sequence
      push_byte(8'hA9, 1'b1);
      push_byte(8'hF7, 1'b0);                   // four byte, largest code point
      push_byte(8'hBF, 1'b0);
      push_byte(8'hBF, 1'b0);
      push_byte(8'hBF, 1'b1);
      push_byte(8'hEF, 1'b0);                   // decodes to the replacement value itself
      push_byte(8'hBF, 1'b0);
      push_byte(8'hBD, 1'b1);
      push_byte(8'h80, 1'b0);                   // stray continuation
      push_byte(8'hFF, 1'b0);                   // stray high bytes
      push_byte(8'hF8, 1'b1);
      push_byte(8'hF0, 1'b0);                   // bad continuation, rescan gives four beats
      push_byte(8'h41, 1'b0);
      push_byte(8'h42, 1'b0);
      push_byte(8'h43, 1'b1);
      push_byte(8'hE2, 1'b0);                   // text ends inside a three byte sequence
      push_byte(8'h82, 1'b1);
      push_byte(8'hC3, 1'b1);                   // lone lead at end of text
      push_byte(8'hE0, 1'b0);                   // overlong zero is decoded as is
      push_byte(8'h80, 1'b0);
      push_byte(8'h80, 1'b1);

      // random texts under several replacement values, extremes included
      settle_idle();
      write_repl('0);
      random_phase(50);

      settle_idle();
      write_repl(21'h1FFFFF);
      random_phase(50);

      // register written while a lead is held; truncation then uses the new value,
      // bad continuation ignored because the text ends
      push_byte(8'hE2, 1'b0);
      settle_idle();
      write_repl(CP_W'($urandom_range(0, 21'h1FFFFF)));
      push_byte(8'h41, 1'b1);
      random_phase(50);

      settle_idle();
      write_repl(21'h00FFFD);
      random_phase(45);

      settle_idle();
      end_of_run <= 1'b1;
      repeat (2) @(posedge clock);

      $display("tb: %0d text bytes driven across %0d replacement settings",
               bytes_sent, settings_used);
      $display("tb: %0d code points compared, %0d of them replacements",
               cps_checked, cps_replaced);
      if (check_failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[filelist.f]
design/u8d_pkg.sv
design/u8d_assembler.sv
design/utf8_codepoint_decoder.sv
bench/u8d_codepoint_checker.sv
bench/tb_utf8_codepoint_decoder.sv
